// ===== hdl/rgb32_to_yuv420_block_top_macros.svh =====
// assertion macros used by the checker file of the rgb to yuv 4:2:0 block
`ifndef RGB32_TO_YUV420_BLOCK_TOP_MACROS_SVH
`define RGB32_TO_YUV420_BLOCK_TOP_MACROS_SVH

// property checked on every rising clk edge, ignored while rst is high
`define R2Y_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clk edge, reset included
`define R2Y_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/r2y_pkg.sv =====
// shared constants and types of the rgb to yuv 4:2:0 block
package r2y_pkg;

  localparam int NUM_LANES = 4;
  localparam int PIXEL_W   = 32;
  localparam int CHAN_W    = 8;
  localparam int PROD_W    = 24;
  localparam int TERM_W    = PROD_W + 1;
  localparam int SUM_W     = TERM_W + 3;

  // luma weights, 16 fractional bits
  localparam int Y_R = 19595;
  localparam int Y_G = 38470;
  localparam int Y_B = 7471;

  // chroma weights, 16 fractional bits
  localparam int FRAC_BITS = 16;
  localparam int CB_R      = 22117;
  localparam int CB_G      = 43419;
  localparam int CR_G      = 54878;
  localparam int CR_B      = 10658;

  // four terms summed, then 3 more bits of shift: 2 for the block average, 1 more halving
  localparam int CHROMA_SHIFT = FRAC_BITS + 3;
  localparam int CHROMA_OFS   = 128;

  typedef enum logic {
    ORDER_BGR = 1'b0,
    ORDER_RGB = 1'b1
  } pixel_fmt_t;

  typedef struct packed {
    logic       enable;
    pixel_fmt_t pixel_fmt;
  } lane_ctrl_t;

  typedef struct packed {
    logic        [CHAN_W-1:0] luma;
    logic signed [TERM_W-1:0] cb_term;
    logic signed [TERM_W-1:0] cr_term;
  } lane_result_t;

endpackage

// ===== hdl/rgb32_to_yuv420_block_top.sv =====
// top level of the rgb32 to yuv 4:2:0 converter for one 2x2 pixel block
//
//   channel   handshake             payload
//   -------   -------------------   ------------------------------------------
//   config    pixel_fmt_we          pixel_fmt_data (1 bit, no read-back)
//   input     in_valid / in_stall   pixel_top_left .. pixel_bottom_right
//   output    out_valid / out_stall luma_top_left .. luma_bottom_right,
//                                   chroma_blue, chroma_red
//
// one 2x2 block per cycle while out_stall is low
// stage 1 is four pixel lanes (luma and chroma terms), stage 2 sums the chroma
// terms and holds the output register
// rst (synchronous) clears the pipeline valid bits and sets pixel_fmt to 0
// out_stall freezes the output register; in_stall rises only when both stages
// hold data and the output is stalled
module rgb32_to_yuv420_block_top import r2y_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_fmt_we,
  input  logic               pixel_fmt_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIXEL_W-1:0] pixel_top_left,
  input  logic [PIXEL_W-1:0] pixel_top_right,
  input  logic [PIXEL_W-1:0] pixel_bottom_left,
  input  logic [PIXEL_W-1:0] pixel_bottom_right,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAN_W-1:0]  luma_top_left,
  output logic [CHAN_W-1:0]  luma_top_right,
  output logic [CHAN_W-1:0]  luma_bottom_left,
  output logic [CHAN_W-1:0]  luma_bottom_right,
  output logic [CHAN_W-1:0]  chroma_blue,
  output logic [CHAN_W-1:0]  chroma_red
);

  pixel_fmt_t        pixel_fmt;
  logic              lane_valid;
  logic              adv_lane;
  logic              adv_out;
  lane_ctrl_t        lane_ctrl;
  logic [PIXEL_W-1:0] pixel [NUM_LANES];
  lane_result_t      lane_res [NUM_LANES];
  logic [CHAN_W-1:0] luma [NUM_LANES];

  // config register, only bit 0 exists
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_fmt <= ORDER_BGR;
    end else if (pixel_fmt_we) begin
      pixel_fmt <= pixel_fmt_t'(pixel_fmt_data);
    end
  end

  // output stage moves when empty or when its result is taken
  assign adv_out  = !out_valid || !out_stall;
  // lane stage moves when empty or when it can hand off to the output stage
  assign adv_lane = !lane_valid || adv_out;
  assign in_stall = !adv_lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (adv_lane) begin
        lane_valid <= in_valid;
      end
      if (adv_out) begin
        out_valid <= lane_valid;
      end
    end
  end

  // lane registers load on every advance, valid or not
  assign lane_ctrl.enable    = adv_lane;
  assign lane_ctrl.pixel_fmt = pixel_fmt;

  assign pixel[0] = pixel_top_left;
  assign pixel[1] = pixel_top_right;
  assign pixel[2] = pixel_bottom_left;
  assign pixel[3] = pixel_bottom_right;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    r2y_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .pixel  (pixel[i]),
      .result (lane_res[i])
    );
  end

  r2y_merge u_merge (
    .clk         (clk),
    .enable      (adv_out),
    .lane_res    (lane_res),
    .luma        (luma),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red)
  );

  assign luma_top_left     = luma[0];
  assign luma_top_right    = luma[1];
  assign luma_bottom_left  = luma[2];
  assign luma_bottom_right = luma[3];

endmodule

// ===== hdl/r2y_lane.sv =====
// one pixel lane: byte unpack, luma and signed 9.16 chroma terms, registered
module r2y_lane import r2y_pkg::*; (
  input  logic               clk,
  input  lane_ctrl_t         ctrl,
  input  logic [PIXEL_W-1:0] pixel,
  output lane_result_t       result
);

  logic [CHAN_W-1:0] r;
  logic [CHAN_W-1:0] g;
  logic [CHAN_W-1:0] b;
  logic [PROD_W-1:0] y_sum;
  logic [PROD_W-1:0] cb_pos;
  logic [PROD_W-1:0] cb_neg;
  logic [PROD_W-1:0] cr_pos;
  logic [PROD_W-1:0] cr_neg;
  lane_result_t      result_next;

  always_comb begin
    if (ctrl.pixel_fmt == ORDER_RGB) begin
      r = pixel[15:8];
      g = pixel[23:16];
      b = pixel[31:24];
    end else begin
      r = pixel[23:16];
      g = pixel[15:8];
      b = pixel[7:0];
    end
  end

  // all weighted sums stay below 2^24
  always_comb begin
    y_sum  = PROD_W'(Y_R * int'(r)) + PROD_W'(Y_G * int'(g)) + PROD_W'(Y_B * int'(b));
    cb_pos = {b, FRAC_BITS'(0)};
    cb_neg = PROD_W'(CB_R * int'(r)) + PROD_W'(CB_G * int'(g));
    cr_pos = {r, FRAC_BITS'(0)};
    cr_neg = PROD_W'(CR_G * int'(g)) + PROD_W'(CR_B * int'(b));
    result_next.luma    = y_sum[PROD_W-1:FRAC_BITS];
    result_next.cb_term = $signed({1'b0, cb_pos}) - $signed({1'b0, cb_neg});
    result_next.cr_term = $signed({1'b0, cr_pos}) - $signed({1'b0, cr_neg});
  end

  always_ff @(posedge clk) begin
    if (ctrl.enable) begin
      result <= result_next;
    end
  end

endmodule

// ===== hdl/r2y_merge.sv =====
// merge stage: block chroma from the four lane terms, output register
module r2y_merge import r2y_pkg::*; (
  input  logic              clk,
  input  logic              enable,
  input  lane_result_t      lane_res [NUM_LANES],
  output logic [CHAN_W-1:0] luma [NUM_LANES],
  output logic [CHAN_W-1:0] chroma_blue,
  output logic [CHAN_W-1:0] chroma_red
);

  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'(CHROMA_OFS) <<< CHROMA_SHIFT;

  logic signed [SUM_W-1:0] cb_sum;
  logic signed [SUM_W-1:0] cr_sum;

  // biased sums are never negative, so a plain bit slice is the floor shift
  always_comb begin
    cb_sum = BIAS;
    cr_sum = BIAS;
    for (int i = 0; i < NUM_LANES; i++) begin
      cb_sum = cb_sum + SUM_W'(lane_res[i].cb_term);
      cr_sum = cr_sum + SUM_W'(lane_res[i].cr_term);
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        luma[i] <= lane_res[i].luma;
      end
      chroma_blue <= cb_sum[CHROMA_SHIFT+CHAN_W-1:CHROMA_SHIFT];
      chroma_red  <= cr_sum[CHROMA_SHIFT+CHAN_W-1:CHROMA_SHIFT];
    end
  end

endmodule

// ===== hdl/r2y_checker.sv =====
// port-level checker for the rgb to yuv 4:2:0 block, bound to the top level
`include "rgb32_to_yuv420_block_top_macros.svh"

module r2y_checker import r2y_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CHAN_W-1:0]  luma_top_left,
  input logic [CHAN_W-1:0]  luma_top_right,
  input logic [CHAN_W-1:0]  luma_bottom_left,
  input logic [CHAN_W-1:0]  luma_bottom_right,
  input logic [CHAN_W-1:0]  chroma_blue,
  input logic [CHAN_W-1:0]  chroma_red
);

  // reset empties the pipeline
  `R2Y_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "out_valid after reset")

  // a stalled result stays offered
  `R2Y_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")

  // a stalled result keeps its payload
  `R2Y_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(luma_top_left) && $stable(luma_top_right) && $stable(luma_bottom_left) && $stable(luma_bottom_right) && $stable(chroma_blue) && $stable(chroma_red), "stalled payload changed")

  // input backpressure only comes from a stalled, full output
  `R2Y_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without cause")

  // an input transfer followed by a free output reaches out_valid through the lane and output registers
  `R2Y_ASSERT(a_latency, (in_valid && !in_stall) ##1 !out_stall |=> out_valid, "transfer lost in pipeline")

endmodule

bind rgb32_to_yuv420_block_top r2y_checker u_checker (.*);
